FILE: rtl/core/ssu_pkg.sv
// Shared types, constants and microcode helpers for the square root step search unit.
package ssu_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int INT_BITS_DEF  = 16;
  localparam int VALUE_W       = 32;
  localparam int ROOT_W        = 25;
  localparam int TOL_W         = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

  // Bit width of the largest root magnitude the search may reach.
  function automatic int root_exp(input int frac_bits, input int int_bits);
    int e;
    e = (int_bits >> 1) + frac_bits + 1;
    if (e > 31) e = 31;
    return e;
  endfunction

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_ERR,
    S_TEST,
    S_ZERO,
    S_INNER,
    S_LIMIT,
    S_MOVE,
    S_ISQ,
    S_IERR,
    S_HALVE,
    S_DONE
  } step_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQUARE,
    OP_ERROR,
    OP_MARK,
    OP_MOVE,
    OP_HALVE,
    OP_PUBLISH
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_IN_TOL,
    C_STEP_ZERO,
    C_NO_MOVE,
    C_RUNAWAY,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump_hit;
    step_t jump_miss;
  } ucode_t;

  typedef struct packed {
    logic in_tol;
    logic step_zero;
    logic no_move;
    logic runaway;
  } dp_status_t;

  function automatic ucode_t uc(input op_t op, input cond_t cond,
                                input step_t hit, input step_t miss);
    ucode_t w;
    w.op        = op;
    w.cond      = cond;
    w.jump_hit  = hit;
    w.jump_miss = miss;
    return w;
  endfunction

endpackage

FILE: rtl/core/ssu_ucode_rom.sv
// Microcode program of the step search: one control word per step.
module ssu_ucode_rom (
  input  ssu_pkg::step_t  pc,
  output ssu_pkg::ucode_t word
);

  always_comb begin
    unique case (pc)
      ssu_pkg::S_IDLE:  word = ssu_pkg::uc(ssu_pkg::OP_LOAD, ssu_pkg::C_IN_VALID,
                                           ssu_pkg::S_SQ, ssu_pkg::S_IDLE);
      ssu_pkg::S_SQ:    word = ssu_pkg::uc(ssu_pkg::OP_SQUARE, ssu_pkg::C_ALWAYS,
                                           ssu_pkg::S_ERR, ssu_pkg::S_ERR);
      ssu_pkg::S_ERR:   word = ssu_pkg::uc(ssu_pkg::OP_ERROR, ssu_pkg::C_ALWAYS,
                                           ssu_pkg::S_TEST, ssu_pkg::S_TEST);
      // record the tolerance test so every exit carries the right flag
      ssu_pkg::S_TEST:  word = ssu_pkg::uc(ssu_pkg::OP_MARK, ssu_pkg::C_IN_TOL,
                                           ssu_pkg::S_DONE, ssu_pkg::S_ZERO);
      ssu_pkg::S_ZERO:  word = ssu_pkg::uc(ssu_pkg::OP_NOP, ssu_pkg::C_STEP_ZERO,
                                           ssu_pkg::S_DONE, ssu_pkg::S_INNER);
      ssu_pkg::S_INNER: word = ssu_pkg::uc(ssu_pkg::OP_NOP, ssu_pkg::C_NO_MOVE,
                                           ssu_pkg::S_HALVE, ssu_pkg::S_LIMIT);
      ssu_pkg::S_LIMIT: word = ssu_pkg::uc(ssu_pkg::OP_NOP, ssu_pkg::C_RUNAWAY,
                                           ssu_pkg::S_DONE, ssu_pkg::S_MOVE);
      ssu_pkg::S_MOVE:  word = ssu_pkg::uc(ssu_pkg::OP_MOVE, ssu_pkg::C_ALWAYS,
                                           ssu_pkg::S_ISQ, ssu_pkg::S_ISQ);
      ssu_pkg::S_ISQ:   word = ssu_pkg::uc(ssu_pkg::OP_SQUARE, ssu_pkg::C_ALWAYS,
                                           ssu_pkg::S_IERR, ssu_pkg::S_IERR);
      ssu_pkg::S_IERR:  word = ssu_pkg::uc(ssu_pkg::OP_ERROR, ssu_pkg::C_ALWAYS,
                                           ssu_pkg::S_INNER, ssu_pkg::S_INNER);
      // error still matches the root, so go straight back to the test
      ssu_pkg::S_HALVE: word = ssu_pkg::uc(ssu_pkg::OP_HALVE, ssu_pkg::C_ALWAYS,
                                           ssu_pkg::S_TEST, ssu_pkg::S_TEST);
      ssu_pkg::S_DONE:  word = ssu_pkg::uc(ssu_pkg::OP_PUBLISH, ssu_pkg::C_OUT_FREE,
                                           ssu_pkg::S_IDLE, ssu_pkg::S_DONE);
      default:          word = ssu_pkg::uc(ssu_pkg::OP_NOP, ssu_pkg::C_ALWAYS,
                                           ssu_pkg::S_IDLE, ssu_pkg::S_IDLE);
    endcase
  end

endmodule

FILE: rtl/core/ssu_sequencer.sv
// Step counter and conditional jump logic driving the datapath from the microcode ROM.
module ssu_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_free,
  input  ssu_pkg::dp_status_t status,
  output ssu_pkg::op_t        op,
  output logic                at_idle
);

  ssu_pkg::step_t  pc_r;
  ssu_pkg::step_t  pc_nxt;
  ssu_pkg::ucode_t word;
  logic            cond_hit;

  ssu_ucode_rom u_rom (
    .pc   (pc_r),
    .word (word)
  );

  always_comb begin
    unique case (word.cond)
      ssu_pkg::C_ALWAYS:    cond_hit = 1'b1;
      ssu_pkg::C_IN_VALID:  cond_hit = in_valid;
      ssu_pkg::C_IN_TOL:    cond_hit = status.in_tol;
      ssu_pkg::C_STEP_ZERO: cond_hit = status.step_zero;
      ssu_pkg::C_NO_MOVE:   cond_hit = status.no_move;
      ssu_pkg::C_RUNAWAY:   cond_hit = status.runaway;
      ssu_pkg::C_OUT_FREE:  cond_hit = out_free;
      default:              cond_hit = 1'b1;
    endcase
    pc_nxt = cond_hit ? word.jump_hit : word.jump_miss;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ssu_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    op      = word.op;
    at_idle = (pc_r == ssu_pkg::S_IDLE);
  end

endmodule

FILE: rtl/core/ssu_datapath.sv
// Root, step and error registers with the shared squaring unit of the step search.
module ssu_datapath #(
  parameter int FRAC_BITS = ssu_pkg::FRAC_BITS_DEF,
  parameter int INT_BITS  = ssu_pkg::INT_BITS_DEF,
  localparam int RootExp  = ssu_pkg::root_exp(FRAC_BITS, INT_BITS)
) (
  input  logic                         clk,
  input  ssu_pkg::op_t                 op,
  input  logic [ssu_pkg::VALUE_W-1:0]  in_value,
  input  logic [ssu_pkg::TOL_W-1:0]    tol,
  output ssu_pkg::dp_status_t          status,
  output logic [RootExp-1:0]           root_mag,
  output logic                         converged
);

  localparam int RootW = RootExp + 1;
  localparam int SqW   = 2 * RootExp;
  localparam int VsW   = ssu_pkg::VALUE_W + FRAC_BITS;
  localparam int DiffW = ((SqW > VsW) ? SqW : VsW) + 1;
  localparam int StepW = FRAC_BITS + 1;

  localparam logic [RootW-1:0]   RootOne = RootW'(1) << FRAC_BITS;
  localparam logic [RootExp-1:0] MagOne  = RootExp'(1) << FRAC_BITS;
  localparam logic [StepW-1:0]   StepOne = StepW'(1) << FRAC_BITS;

  logic        [RootW-1:0]   root_r;
  logic        [RootExp-1:0] mag_r;
  logic        [StepW-1:0]   smag_r;
  logic                      sneg_r;
  logic        [VsW-1:0]     vs_r;
  logic        [SqW-1:0]     sq_r;
  logic signed [DiffW-1:0]   diff_r;
  logic                      conv_r;

  logic        [RootW:0]     root_x;
  logic        [RootW:0]     step_x;
  logic        [RootW:0]     next_sum;
  logic        [RootW:0]     next_mag;
  logic        [SqW-1:0]     sq_nxt;
  logic signed [DiffW-1:0]   diff_nxt;
  logic signed [DiffW-1:0]   tol_x;
  logic signed [DiffW-1:0]   tol_neg;

  always_comb begin
    root_x   = {root_r[RootW-1], root_r};
    step_x   = (RootW + 1)'(smag_r);
    next_sum = sneg_r ? (root_x - step_x) : (root_x + step_x);
    next_mag = next_sum[RootW] ? (~next_sum + 1'b1) : next_sum;
    sq_nxt   = {{RootExp{1'b0}}, mag_r} * {{RootExp{1'b0}}, mag_r};
    diff_nxt = $signed(DiffW'(sq_r)) - $signed(DiffW'(vs_r));
    tol_x    = DiffW'({tol, {FRAC_BITS{1'b0}}});
    tol_neg  = -tol_x;

    status.in_tol    = (diff_r <= tol_x) && (diff_r >= tol_neg);
    status.step_zero = (smag_r == '0);
    // stop moving once the error is zero or its sign parts from the step's
    status.no_move   = (diff_r == '0) || (diff_r[DiffW-1] != sneg_r);
    status.runaway   = |next_mag[RootW:RootExp];
  end

  always_ff @(posedge clk) begin
    case (op)
      ssu_pkg::OP_LOAD: begin
        root_r <= RootOne;
        mag_r  <= MagOne;
        smag_r <= StepOne;
        sneg_r <= 1'b0;
        vs_r   <= {in_value, {FRAC_BITS{1'b0}}};
      end
      ssu_pkg::OP_SQUARE: sq_r   <= sq_nxt;
      ssu_pkg::OP_ERROR:  diff_r <= diff_nxt;
      ssu_pkg::OP_MARK:   conv_r <= status.in_tol;
      ssu_pkg::OP_MOVE: begin
        root_r <= next_sum[RootW-1:0];
        mag_r  <= next_mag[RootExp-1:0];
      end
      ssu_pkg::OP_HALVE: begin
        smag_r <= smag_r >> 1;
        sneg_r <= ~sneg_r;
      end
      default: ;
    endcase
  end

  assign root_mag  = mag_r;
  assign converged = conv_r;

endmodule

FILE: rtl/core/square_root_step_search_unit.sv
// Run time is set by the microcode walk, one datapath op a cycle,
// plus any output stall while publishing.
// Throughput: one transaction at a time; the next is taken once the sequencer is back at idle.
// A finished result waits in the output register while the next transaction is worked on.
// Reset (rst_n low, synchronous): step counter to idle, output empty, tolerance to 7.
module square_root_step_search_unit #(
  parameter int FRAC_BITS = ssu_pkg::FRAC_BITS_DEF,
  parameter int INT_BITS  = ssu_pkg::INT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ssu_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ssu_pkg::ROOT_W-1:0]  out_root,
  output logic                        out_converged,
  input  logic                        cfg_wr_en,
  input  logic [ssu_pkg::TOL_W-1:0]   cfg_wr_data
);

  localparam int RootExp  = ssu_pkg::root_exp(FRAC_BITS, INT_BITS);
  localparam int RootOutW = ssu_pkg::ROOT_W;

  logic [ssu_pkg::TOL_W-1:0] tol_r;
  logic                      out_valid_r;
  logic [RootOutW-1:0]       out_root_r;
  logic                      out_conv_r;

  ssu_pkg::op_t              op;
  ssu_pkg::dp_status_t       status;
  logic                      at_idle;
  logic                      out_free;
  logic                      publish;
  logic [RootExp-1:0]        root_mag;
  logic                      converged;

  assign out_free = !out_valid_r || !out_stall;
  assign publish  = (op == ssu_pkg::OP_PUBLISH) && out_free;

  ssu_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .status   (status),
    .op       (op),
    .at_idle  (at_idle)
  );

  ssu_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .INT_BITS  (INT_BITS)
  ) u_dp (
    .clk       (clk),
    .op        (op),
    .in_value  (in_value),
    .tol       (tol_r),
    .status    (status),
    .root_mag  (root_mag),
    .converged (converged)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= ssu_pkg::TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  // hold the result until taken; refill in the same cycle it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (publish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (publish) begin
      out_root_r <= RootOutW'(root_mag);
      out_conv_r <= converged;
    end
  end

  assign in_stall      = !at_idle;
  assign out_valid     = out_valid_r;
  assign out_root      = out_root_r;
  assign out_converged = out_conv_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("sequencer did not leave idle after accepting a transaction");

  a_publish_fill: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> $past(op == ssu_pkg::OP_PUBLISH))
    else $error("output register filled outside the publish step");

  a_idle_after_publish: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(in_stall)) |-> $past(publish))
    else $error("sequencer returned to idle without publishing a result");

endmodule
